@@ rtl/dmx_pattern_frame_generator_defines.svh @@
// Assertion macros shared by the DMX pattern frame generator RTL.
// Depends on nothing; users must have clk and rst in scope.
`ifndef DMX_PATTERN_FRAME_GENERATOR_DEFINES_SVH
`define DMX_PATTERN_FRAME_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DPFG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DPFG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dpfg_pkg.sv @@
// Package for the DMX pattern frame generator: item types, codes, constants.
// No dependencies.
package dpfg_pkg;

  localparam int SLOT_COUNT_DEF = 512;
  localparam int CHASE_W        = 7;   // fixture index width at the largest slot count
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 2;

  // command codes
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_SET   = 3'd1;
  localparam logic [2:0] CMD_SEND  = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_START = 3'd4;
  localparam logic [2:0] CMD_STOP  = 3'd5;
  localparam logic [2:0] CMD_READ  = 3'd6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CYCLES   = 2'd2;

  // pattern modes
  localparam logic [2:0] MODE_FADE    = 3'd1;
  localparam logic [2:0] MODE_RAINBOW = 3'd2;
  localparam logic [2:0] MODE_STROBE  = 3'd3;
  localparam logic [2:0] MODE_CHASE   = 3'd4;
  localparam logic [2:0] MODE_ALT     = 3'd5;

  localparam logic [2:0]  MODE_RESET       = MODE_FADE;
  localparam logic [15:0] PERIOD_RESET     = 16'd50;
  localparam logic [15:0] MAX_CYCLES_RESET = 16'd0;

  typedef struct packed {
    logic [2:0] cmd;
    logic [9:0] slot_address;
    logic [7:0] slot_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       frame_sent;
    logic       pattern_running;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic [7:0]         fade_level;
    logic               fade_rising;
    logic [7:0]         hue_phase;
    logic               strobe_lit;
    logic [CHASE_W-1:0] chase_index;
    logic               alt_phase;
  } phase_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // Distance of a hue from mid-scale.
  function automatic logic [7:0] tri_wave(input logic [7:0] h);
    return (h >= 8'd128) ? (h - 8'd128) : (8'd128 - h);
  endfunction

endpackage

@@ rtl/dpfg_stream_if.sv @@
// Valid/ready channel carrying one item per handshake.
// Payload type is set per instance; no other dependencies.
interface dpfg_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/dpfg_slot_ram.sv @@
// Single-port slot level memory with registered read.
// Depends on nothing but its parameter.
module dpfg_slot_ram #(
  parameter int SLOT_COUNT = 512,
  parameter int SLOT_AW    = $clog2(SLOT_COUNT)
) (
  input  logic               clk,
  input  logic               we,
  input  logic               re,
  input  logic [SLOT_AW-1:0] addr,
  input  logic [7:0]         wdata,
  output logic [7:0]         rdata
);

  logic [7:0] mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/dpfg_pattern.sv @@
// Pattern value of one slot from the mode, the phase state and the slot index.
// Depends on dpfg_pkg.
module dpfg_pattern #(
  parameter int SLOT_COUNT = 512,
  parameter int SLOT_AW    = $clog2(SLOT_COUNT)
) (
  input  logic [2:0]          mode,
  input  dpfg_pkg::phase_t    phase,
  input  logic [SLOT_AW-1:0]  idx,
  output logic [7:0]          value
);
  import dpfg_pkg::*;

  logic [1:0]         lane;
  logic [CHASE_W-1:0] fixture;

  assign lane    = idx[1:0];
  assign fixture = CHASE_W'(idx >> 2);

  always_comb begin
    unique case (mode)
      MODE_FADE: begin
        unique case (lane)
          2'd0:    value = phase.fade_level;
          2'd1:    value = 8'd255 - phase.fade_level;
          default: value = 8'd0;
        endcase
      end
      MODE_RAINBOW: begin
        unique case (lane)
          2'd0:    value = tri_wave(phase.hue_phase);
          2'd1:    value = tri_wave(phase.hue_phase + 8'd85);
          2'd2:    value = tri_wave(phase.hue_phase + 8'd170);
          default: value = 8'd0;
        endcase
      end
      MODE_STROBE: value = phase.strobe_lit ? 8'd255 : 8'd0;
      MODE_CHASE:
        value = (fixture == phase.chase_index && lane != 2'd3) ? 8'd255 : 8'd0;
      MODE_ALT:
        value = (lane != 2'd3 && (!idx[2] == phase.alt_phase)) ? 8'd255 : 8'd0;
      default: value = 8'd0;
    endcase
  end

endmodule

@@ rtl/dmx_pattern_frame_generator.sv @@
// DMX pattern frame generator, top level. One item in flight at a time; the next item
//   is accepted at the earliest at the edge that takes the previous result.
// Set, send, start, stop, unused, rejected read and a tick without a slot rewrite complete at
//   accept; a valid read passes through READ and DONE, a clear or rewrite through SWEEP and DONE.
// Reset: synchronous; a clearing pass over all SLOT_COUNT slots zeroes the slot memory,
//   during which no item is accepted (configuration writes are taken).
`include "dmx_pattern_frame_generator_defines.svh"

module dmx_pattern_frame_generator #(
  parameter int SLOT_COUNT = dpfg_pkg::SLOT_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  dpfg_stream_if.sink                    cmd_ch,
  dpfg_stream_if.source                  res_ch,
  input  logic                           cfg_we,
  input  logic [dpfg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dpfg_pkg::CFG_W-1:0]     cfg_data
);
  import dpfg_pkg::*;

  localparam int SLOT_AW  = $clog2(SLOT_COUNT);
  localparam int FIXTURES = SLOT_COUNT / 4;

  // configuration registers
  logic [2:0]  pattern_mode;
  logic [15:0] period_ms;
  logic [15:0] max_cycles;

  // control and timing state
  state_t       state, state_next;
  logic [SLOT_AW-1:0] idx;
  logic         idx_last;
  logic         sweep_clear;
  logic         pend_read;
  logic [31:0]  ms_clock;
  logic [31:0]  elapsed;        // ms_clock minus time of last update
  logic [31:0]  elapsed_inc;
  logic [31:0]  elapsed_next;
  logic         running, running_next;
  logic [15:0]  cycle_count, cycle_count_next;
  logic [15:0]  cycle_inc;
  phase_t       phase, phase_next;

  // output register
  logic         out_valid;
  out_item_t    out_item;
  logic         out_free;

  // decoded input item
  in_item_t           item;
  logic               in_ready;
  logic               in_fire;
  logic               addr_ok;
  logic [SLOT_AW-1:0] slot_idx;
  logic               due;
  logic               mode_ok;
  logic               go_read;
  logic               go_sweep;
  logic               load_imm;
  logic               load_done;
  out_item_t          imm_item;

  // memory port
  logic               ram_we;
  logic               ram_re;
  logic [SLOT_AW-1:0] ram_addr;
  logic [7:0]         ram_wdata;
  logic [7:0]         ram_rdata;
  logic [7:0]         pat_value;

  assign item     = cmd_ch.payload;
  assign out_free = !out_valid || res_ch.ready;
  assign in_fire  = cmd_ch.valid && in_ready;
  assign cmd_ch.ready  = in_ready;
  assign res_ch.valid  = out_valid;
  assign res_ch.payload = out_item;

  assign addr_ok  = (item.slot_address != 10'd0) && (item.slot_address <= 10'(SLOT_COUNT));
  assign slot_idx = SLOT_AW'(item.slot_address - 10'd1);
  assign idx_last = (idx == SLOT_AW'(SLOT_COUNT - 1));

  // Update is due, while running, when the elapsed time after this tick reaches the period.
  assign elapsed_inc = elapsed + 32'd1;
  assign due         = running && (elapsed_inc >= {16'd0, period_ms});
  assign mode_ok     = (pattern_mode >= MODE_FADE) && (pattern_mode <= MODE_ALT);
  assign cycle_inc   = cycle_count + 16'd1;

  assign go_read  = (item.cmd == CMD_READ) && addr_ok;
  assign go_sweep = (item.cmd == CMD_CLEAR) || ((item.cmd == CMD_TICK) && due && mode_ok);

  // Timing and run state after an accepted item.
  always_comb begin
    elapsed_next     = elapsed;
    running_next     = running;
    cycle_count_next = cycle_count;
    case (item.cmd)
      CMD_TICK: begin
        elapsed_next = due ? 32'd0 : elapsed_inc;
        if (due && max_cycles != 16'd0) begin
          if (cycle_inc >= max_cycles) begin
            running_next     = 1'b0;
            cycle_count_next = 16'd0;
          end else begin
            cycle_count_next = cycle_inc;
          end
        end
      end
      CMD_START: begin
        running_next     = 1'b1;
        elapsed_next     = ms_clock;  // last update goes back to time zero
        cycle_count_next = 16'd0;
      end
      CMD_STOP: begin
        running_next     = 1'b0;
        cycle_count_next = 16'd0;
      end
      default: ;
    endcase
  end

  // Result of an item that completes at accept.
  always_comb begin
    imm_item.read_value      = 8'd0;
    imm_item.pattern_running = running_next;
    imm_item.frame_sent      = ((item.cmd == CMD_TICK) && due) || (item.cmd == CMD_SET)
                               || (item.cmd == CMD_SEND);
    imm_item.rejected        = ((item.cmd == CMD_SET) || (item.cmd == CMD_READ)) && !addr_ok;
  end

  // Phase state advanced at the end of a pattern sweep.
  always_comb begin
    phase_next = phase;
    case (pattern_mode)
      MODE_FADE: begin
        phase_next.fade_level = phase.fade_rising ? phase.fade_level + 8'd1
                                                  : phase.fade_level - 8'd1;
        if (phase_next.fade_level == 8'd0 || phase_next.fade_level == 8'd255) begin
          phase_next.fade_rising = !phase.fade_rising;
        end
      end
      MODE_RAINBOW: phase_next.hue_phase = phase.hue_phase + 8'd1;
      MODE_STROBE:  phase_next.strobe_lit = !phase.strobe_lit;
      MODE_CHASE: begin
        phase_next.chase_index = (phase.chase_index == CHASE_W'(FIXTURES - 1))
                                 ? '0 : phase.chase_index + CHASE_W'(1);
      end
      MODE_ALT:     phase_next.alt_phase = !phase.alt_phase;
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:  if (idx_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_fire && go_read) begin
          state_next = ST_READ;
        end else if (in_fire && go_sweep) begin
          state_next = ST_SWEEP;
        end
      end
      ST_READ:  state_next = ST_DONE;
      ST_SWEEP: if (idx_last) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // State outputs: handshake, memory port, result loads.
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = idx;
    ram_wdata = 8'd0;
    load_done = 1'b0;
    unique case (state)
      ST_INIT: ram_we = 1'b1;
      ST_IDLE: begin
        in_ready  = out_free;
        ram_addr  = slot_idx;
        ram_wdata = item.slot_value;
        ram_we    = in_fire && (item.cmd == CMD_SET) && addr_ok;
        ram_re    = in_fire && go_read;
      end
      ST_READ: ;
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_wdata = sweep_clear ? 8'd0 : pat_value;
      end
      ST_DONE: load_done = out_free;
      default: ;
    endcase
  end

  assign load_imm = in_fire && !go_read && !go_sweep;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      idx         <= '0;
      sweep_clear <= 1'b1;
      pend_read   <= 1'b0;
      out_valid   <= 1'b0;
      ms_clock    <= 32'd0;
      elapsed     <= 32'd0;
      running     <= 1'b0;
      cycle_count <= 16'd0;
      phase       <= '{fade_level: 8'd0, fade_rising: 1'b1, hue_phase: 8'd0,
                       strobe_lit: 1'b0, chase_index: '0, alt_phase: 1'b0};
    end else begin
      state <= state_next;
      if (state == ST_INIT || state == ST_SWEEP) begin
        idx <= idx_last ? '0 : idx + SLOT_AW'(1);
      end
      if (in_fire) begin
        sweep_clear <= (item.cmd == CMD_CLEAR);
        pend_read   <= go_read;
        elapsed     <= elapsed_next;
        running     <= running_next;
        cycle_count <= cycle_count_next;
        if (item.cmd == CMD_TICK) begin
          ms_clock <= ms_clock + 32'd1;
        end
      end
      if (state == ST_SWEEP && idx_last && !sweep_clear) begin
        phase <= phase_next;
      end
      if (load_imm || load_done) begin
        out_valid <= 1'b1;
      end else if (res_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; hold until the next load.
  always_ff @(posedge clk) begin
    if (load_imm) begin
      out_item <= imm_item;
    end else if (load_done) begin
      out_item.read_value      <= pend_read ? ram_rdata : 8'd0;
      out_item.frame_sent      <= !pend_read;
      out_item.pattern_running <= running;
      out_item.rejected        <= 1'b0;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode <= MODE_RESET;
      period_ms    <= PERIOD_RESET;
      max_cycles   <= MAX_CYCLES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_MODE: pattern_mode <= cfg_data[2:0];
        CFG_PERIOD_MS:    period_ms    <= cfg_data;
        CFG_MAX_CYCLES:   max_cycles   <= cfg_data;
        default: ;
      endcase
    end
  end

  dpfg_slot_ram #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_AW    (SLOT_AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  dpfg_pattern #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_AW    (SLOT_AW)
  ) u_pattern (
    .mode  (pattern_mode),
    .phase (phase),
    .idx   (idx),
    .value (pat_value)
  );

  // The memory port never reads and writes in the same cycle.
  `DPFG_ASSERT_NOW(a_port_single, ram_re, !ram_we, "slot memory read and write collide")
  // A stopped pattern always has its frame count cleared.
  `DPFG_ASSERT_NOW(a_stop_count, !running, cycle_count == 16'd0, "count nonzero while stopped")
  // Fade direction turns at the ends of the range.
  `DPFG_ASSERT_NOW(a_fade_ends, phase.fade_level == 8'd255 || phase.fade_level == 8'd0,
                   phase.fade_rising == (phase.fade_level == 8'd0), "fade direction wrong at end")
  // An item completing at accept shows its result in the next cycle.
  `DPFG_ASSERT_NEXT(a_imm_result, load_imm, out_valid && state == ST_IDLE,
                    "immediate result not presented")

endmodule

@@ verif/tb_dmx_pattern_frame_generator.sv @@
// Self-checking testbench for the DMX pattern frame generator: directed and random commands.
// Depends on dpfg_pkg and dpfg_stream_if from the RTL, and on the top level under test.
`timescale 1ns / 100ps

module tb_dmx_pattern_frame_generator;
  import dpfg_pkg::*;

  localparam int SLOTS        = SLOT_COUNT_DEF;
  // Watchdog limit; a slow correct run stays well under it.
  localparam int LIMIT_CYCLES = 3_000_000;
  // Longest item is a clear or a pattern sweep.
  localparam int QUIET_CYCLES = SLOTS + 88;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_LIMIT = 10;

  localparam logic [2:0] CMD_UNUSED    = 3'd7;
  // Pattern mode codes outside the defined set.
  localparam logic [2:0] MODE_OFF_LOW  = 3'd0;
  localparam logic [2:0] MODE_OFF_MID  = 3'd6;
  localparam logic [2:0] MODE_OFF_HIGH = 3'd7;

  // Keeps a shadow of the slot store, the clock and the pattern phases, and holds
  // the status each accepted command must produce, oldest first.
  class dmx_frame_scoreboard;
    logic [7:0]  slot_level [SLOTS];
    logic [31:0] ms_count;
    logic [31:0] last_frame_ms;
    bit          pattern_on;
    logic [15:0] frames_done;
    logic [7:0]  fade_lvl;
    bit          fade_up;
    logic [7:0]  hue;
    bit          strobe_on;
    logic [6:0]  chase_fx;
    bit          alt_even;
    logic [2:0]  mode_reg;
    logic [15:0] period_reg;
    logic [15:0] max_frames_reg;
    out_item_t   due_replies [$];
    int          failures;

    function new();
      foreach (slot_level[i]) slot_level[i] = 8'd0;
      ms_count       = '0;
      last_frame_ms  = '0;
      pattern_on     = 1'b0;
      frames_done    = '0;
      fade_lvl       = '0;
      fade_up        = 1'b1;
      hue            = '0;
      strobe_on      = 1'b0;
      chase_fx       = '0;
      alt_even       = 1'b0;
      mode_reg       = MODE_RESET;
      period_reg     = PERIOD_RESET;
      max_frames_reg = MAX_CYCLES_RESET;
      failures       = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_PATTERN_MODE: mode_reg = data[2:0];
        CFG_PERIOD_MS:    period_reg = data;
        CFG_MAX_CYCLES:   max_frames_reg = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] hue_distance(logic [7:0] h);
      return h[7] ? {1'b0, h[6:0]} : 8'd128 - h;
    endfunction

    // Rewrite every slot from the current mode (an undefined mode leaves them), then step that mode's phase.
    function void paint_pattern();
      logic [6:0] fx;
      logic [1:0] lane;
      logic [7:0] v;
      logic [7:0] hue_g;
      logic [7:0] hue_b;
      hue_g = hue + 8'd85;
      hue_b = hue + 8'd170;
      for (int s = 0; s < SLOTS; s++) begin
        fx   = 7'(s / 4);
        lane = 2'(s % 4);
        v    = slot_level[s];
        case (mode_reg)
          MODE_FADE:
            v = (lane == 2'd0) ? fade_lvl : (lane == 2'd1) ? 8'd255 - fade_lvl : 8'd0;
          MODE_RAINBOW:
            v = (lane == 2'd0) ? hue_distance(hue) :
                (lane == 2'd1) ? hue_distance(hue_g) :
                (lane == 2'd2) ? hue_distance(hue_b) : 8'd0;
          MODE_STROBE:
            v = strobe_on ? 8'hFF : 8'h00;
          MODE_CHASE:
            v = (fx == chase_fx && lane != 2'd3) ? 8'hFF : 8'h00;
          MODE_ALT:
            v = (lane != 2'd3 && ((fx[0] == 1'b0) == alt_even)) ? 8'hFF : 8'h00;
          default: ;
        endcase
        slot_level[s] = v;
      end
      case (mode_reg)
        MODE_FADE: begin
          fade_lvl = fade_up ? fade_lvl + 8'd1 : fade_lvl - 8'd1;
          if (fade_lvl == 8'd0 || fade_lvl == 8'd255) fade_up = !fade_up;
        end
        MODE_RAINBOW: hue = hue + 8'd1;
        MODE_STROBE:  strobe_on = !strobe_on;
        MODE_CHASE:   chase_fx = 7'((int'(chase_fx) + 1) % (SLOTS / 4));
        MODE_ALT:     alt_even = !alt_even;
        default: ;
      endcase
    endfunction

    function void note_command(in_item_t it);
      out_item_t r;
      bit        addr_ok;
      r       = '0;
      addr_ok = (it.slot_address >= 10'd1) && (int'(it.slot_address) <= SLOTS);
      case (it.cmd)
        CMD_TICK: begin
          ms_count = ms_count + 32'd1;
          if (pattern_on && (ms_count - last_frame_ms) >= {16'd0, period_reg}) begin
            last_frame_ms = ms_count;
            paint_pattern();
            r.frame_sent = 1'b1;
            if (max_frames_reg != 16'd0) begin
              frames_done = frames_done + 16'd1;
              if (frames_done >= max_frames_reg) begin
                pattern_on  = 1'b0;
                frames_done = '0;
              end
            end
          end
        end
        CMD_SET: begin
          if (addr_ok) slot_level[it.slot_address - 10'd1] = it.slot_value;
          else r.rejected = 1'b1;
          r.frame_sent = 1'b1;
        end
        CMD_SEND: r.frame_sent = 1'b1;
        CMD_CLEAR: begin
          foreach (slot_level[i]) slot_level[i] = 8'd0;
          r.frame_sent = 1'b1;
        end
        CMD_START: begin
          pattern_on    = 1'b1;
          last_frame_ms = '0;
          frames_done   = '0;
        end
        CMD_STOP: begin
          pattern_on  = 1'b0;
          frames_done = '0;
        end
        CMD_READ: begin
          if (addr_ok) r.read_value = slot_level[it.slot_address - 10'd1];
          else r.rejected = 1'b1;
        end
        default: ;
      endcase
      r.pattern_running = pattern_on;
      due_replies.push_back(r);
    endfunction

    function string show(out_item_t r);
      return $sformatf("read_value=%0d frame_sent=%b pattern_running=%b rejected=%b",
                       r.read_value, r.frame_sent, r.pattern_running, r.rejected);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_replies.size() == 0) begin
        flag({"result with nothing outstanding: ", show(got)});
        return;
      end
      want = due_replies.pop_front();
      if (got.read_value !== want.read_value || got.frame_sent !== want.frame_sent ||
          got.pattern_running !== want.pattern_running || got.rejected !== want.rejected)
        flag({"expected ", show(want), " got ", show(got)});
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  dpfg_stream_if #(.payload_t(in_item_t))  cmd_if ();
  dpfg_stream_if #(.payload_t(out_item_t)) res_if ();

  dmx_pattern_frame_generator i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_ch    (cmd_if),
    .res_ch    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dmx_frame_scoreboard sb = new();

  // Percent chance per cycle that the sender holds off / the receiver stalls.
  int gap_pct  = 7;
  int hold_pct = 64;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: check each accepted status item, then pick ready for the next cycle.
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) sb.check_result(res_if.payload);
    res_if.ready <= ($urandom_range(99) >= hold_pct);
  end

  // Offer one command and hold it until the block takes it. Valid stays high on
  // return so back-to-back items never drop and raise valid in one time step.
  task automatic send_item(in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= it;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    sb.note_command(it);
  endtask

  task automatic issue(logic [2:0] cmd, logic [9:0] addr, logic [7:0] val);
    in_item_t it;
    it.cmd          = cmd;
    it.slot_address = addr;
    it.slot_value   = val;
    send_item(it);
  endtask

  // Drop valid and hold off until every outstanding status item has come back.
  task automatic settle_block();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.due_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges; only call while idle.
  task automatic configure(logic [2:0] mode, logic [15:0] period, logic [15:0] max_frames);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PATTERN_MODE;
    cfg_data  <= {13'd0, mode};
    @(posedge clk);
    sb.set_register(CFG_PATTERN_MODE, {13'd0, mode});
    cfg_index <= CFG_PERIOD_MS;
    cfg_data  <= period;
    @(posedge clk);
    sb.set_register(CFG_PERIOD_MS, period);
    cfg_index <= CFG_MAX_CYCLES;
    cfg_data  <= max_frames;
    @(posedge clk);
    sb.set_register(CFG_MAX_CYCLES, max_frames);
    cfg_we <= 1'b0;
  endtask

  // Mostly ticks and valid slot traffic; restart the pattern often when it has
  // stopped so the sweep logic stays busy. One address in ten is unconstrained.
  function automatic in_item_t make_random(int tick_pct);
    in_item_t it;
    int       pick;
    it.slot_value   = 8'($urandom_range(255));
    it.slot_address = ($urandom_range(9) == 0) ? 10'($urandom_range(1023))
                                               : 10'($urandom_range(SLOTS, 1));
    if (!sb.pattern_on && $urandom_range(3) == 0) begin
      it.cmd = CMD_START;
    end else if ($urandom_range(99) < tick_pct) begin
      it.cmd = CMD_TICK;
    end else begin
      pick = $urandom_range(99);
      if (pick < 30)      it.cmd = CMD_SET;
      else if (pick < 60) it.cmd = CMD_READ;
      else if (pick < 68) it.cmd = CMD_SEND;
      else if (pick < 71) it.cmd = CMD_CLEAR;
      else if (pick < 85) it.cmd = CMD_START;
      else if (pick < 91) it.cmd = CMD_STOP;
      else                it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  task automatic run_phase(logic [2:0] mode, logic [15:0] period, logic [15:0] max_frames,
                           int n_items, int tick_pct);
    settle_block();
    configure(mode, period, max_frames);
    for (int n = 0; n < n_items; n++) begin
      // Now and then hold off until the block has answered everything.
      if ($urandom_range(63) == 0) settle_block();
      send_item(make_random(tick_pct));
    end
  endtask

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("dmx_pattern_frame_generator test failed");
    $finish;
  end

  initial begin
    cmd_if.valid   = 1'b0;
    cmd_if.payload = '0;
    res_if.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Registers are taken during the clearing pass after reset.
    configure(MODE_FADE, 16'd0, 16'd2);

    // Directed: address and level extremes, rejects, every command, cycle limit.
    issue(CMD_READ,   10'd1,    8'd0);
    issue(CMD_SET,    10'd1,    8'd255);
    issue(CMD_SET,    10'd512,  8'd170);
    issue(CMD_SET,    10'd0,    8'd85);
    issue(CMD_SET,    10'd513,  8'd0);
    issue(CMD_SET,    10'd1023, 8'd255);
    issue(CMD_READ,   10'd1,    8'd0);
    issue(CMD_READ,   10'd512,  8'd255);
    issue(CMD_READ,   10'd0,    8'd0);
    issue(CMD_READ,   10'd1023, 8'd0);
    issue(CMD_SEND,   10'd0,    8'd0);
    issue(CMD_UNUSED, 10'd1023, 8'd255);
    issue(CMD_TICK,   10'd0,    8'd0);
    issue(CMD_START,  10'd0,    8'd0);
    issue(CMD_TICK,   10'd0,    8'd0);
    issue(CMD_READ,   10'd2,    8'd0);
    issue(CMD_TICK,   10'd0,    8'd0);
    issue(CMD_TICK,   10'd0,    8'd0);
    issue(CMD_READ,   10'd1,    8'd0);
    issue(CMD_START,  10'd0,    8'd0);
    issue(CMD_STOP,   10'd0,    8'd0);
    issue(CMD_CLEAR,  10'd0,    8'd0);
    issue(CMD_READ,   10'd512,  8'd0);
    issue(CMD_SET,    10'd256,  8'd85);
    issue(CMD_READ,   10'd256,  8'd0);

    // Slow receiver, mostly eager sender.
    gap_pct  = 7;
    hold_pct = 64;
    run_phase(MODE_FADE,     16'd0,     16'd0,     160, 70);
    run_phase(MODE_RAINBOW,  16'd1,     16'd0,     100, 70);
    run_phase(MODE_STROBE,   16'd2,     16'd3,     100, 50);

    // Slow sender, mostly eager receiver.
    gap_pct  = 64;
    hold_pct = 7;
    run_phase(MODE_CHASE,    16'd0,     16'd0,     220, 70);
    run_phase(MODE_ALT,      16'd5,     16'd1,     100, 50);
    run_phase(MODE_OFF_LOW,  16'd0,     16'd65535,  80, 70);

    // Full rate on both sides.
    gap_pct  = 0;
    hold_pct = 0;
    run_phase(MODE_OFF_MID,  16'd65535, 16'd0,      80, 50);
    run_phase(MODE_OFF_HIGH, 16'd1,     16'd2,      80, 50);
    run_phase(MODE_RAINBOW,  16'd0,     16'd0,      80, 70);
    run_phase(MODE_FADE,     16'd0,     16'd0,     150, 70);

    // Drain, then watch a while longer for stray results.
    settle_block();
    repeat (QUIET_CYCLES) @(posedge clk);
    while (sb.due_replies.size() != 0)
      sb.flag({"no result for ", sb.show(sb.due_replies.pop_front())});

    if (sb.failures == 0)
      $display("dmx_pattern_frame_generator test passed");
    else
      $display("dmx_pattern_frame_generator test failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/dpfg_pkg.sv
rtl/dpfg_stream_if.sv
rtl/dpfg_slot_ram.sv
rtl/dpfg_pattern.sv
rtl/dmx_pattern_frame_generator.sv
verif/tb_dmx_pattern_frame_generator.sv
